/* rtl/ecpd_pkg.sv */
// Shared types and constants for the eight-channel phase dimmer.
// No dependencies; imported by every module of the block.
`default_nettype none
package ecpd_pkg;

  // Input operation codes (in_tuser)
  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_ZERO = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MAINS_60HZ = 1'b0;
  localparam logic CFG_MIN_DELAY  = 1'b1;

  // Delay mapping constants
  localparam logic [15:0] FULL_SCALE    = 16'hFFFF;
  localparam logic [15:0] SPAN60_END    = 16'd33000;
  localparam logic [15:0] SPAN50_END    = 16'd40000;
  localparam logic [15:0] BASE50        = 16'd8000;
  localparam logic [15:0] MIN_DELAY_RST = 16'd2000;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Gate output width
  localparam int GATE_W = 8;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_ZERO = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_kind_t;

  // One queued command
  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  ch;
    logic [15:0] delay;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/ecpd_front.sv */
// Front end: input handshake, configuration registers, classification and
// level-to-delay mapping pipeline. Depends on ecpd_pkg.
`default_nettype none
module ecpd_front #(
  parameter int CHANNELS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // config port
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_wdata,
  // input item
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_op,
  input  wire logic [2:0]    in_ch,
  input  wire logic [15:0]   in_level,
  // queue push side
  output logic               push,
  output ecpd_pkg::cmd_t     push_cmd,
  input  wire logic          q_full
);
  import ecpd_pkg::*;

  localparam logic [4:0] CH_LIM = 5'(CHANNELS);

  logic        mains_60hz_r;
  logic [15:0] min_delay_r;

  // stage A: classified item, operands of the multiply
  logic        a_v_r;
  cmd_kind_t   a_kind_r;
  logic [2:0]  a_ch_r;
  logic [15:0] a_x_r, a_span_r, a_base_r;
  // stage B: product
  logic        b_v_r;
  cmd_kind_t   b_kind_r;
  logic [2:0]  b_ch_r;
  logic [31:0] b_prod_r;
  logic [15:0] b_base_r;
  // stage C: quotient
  logic        c_v_r;
  cmd_kind_t   c_kind_r;
  logic [2:0]  c_ch_r;
  logic [15:0] c_quo_r;
  logic [15:0] c_base_r;

  logic        adv;
  cmd_kind_t   kind_nxt;
  logic [15:0] span_end, base_sel, span_nxt;
  logic [32:0] div_sum;
  logic [16:0] delay_sum;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mains_60hz_r <= 1'b0;
      min_delay_r  <= MIN_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAINS_60HZ: mains_60hz_r <= cfg_wdata[0];
        CFG_MIN_DELAY:  min_delay_r  <= cfg_wdata;
        default:        mains_60hz_r <= mains_60hz_r;
      endcase
    end
  end

  // whole front stalls only when the last stage cannot push
  assign adv      = !(c_v_r && q_full);
  assign in_ready = adv;

  // classify; out-of-range channels and the spare code do nothing
  always_comb begin
    unique case (in_op)
      OP_SET:  kind_nxt = ({2'b00, in_ch} < CH_LIM) ? CMD_SET : CMD_NOP;
      OP_ZERO: kind_nxt = CMD_ZERO;
      OP_TICK: kind_nxt = CMD_TICK;
      default: kind_nxt = CMD_NOP;
    endcase
  end

  // span and base for the selected mains frequency
  always_comb begin
    span_end = mains_60hz_r ? SPAN60_END : SPAN50_END;
    base_sel = mains_60hz_r ? min_delay_r : BASE50;
    span_nxt = (span_end > min_delay_r) ? (span_end - min_delay_r) : 16'd0;
  end

  // exact floor(p / 65535) for p < 2^32: (p + (p >> 16) + 1) >> 16
  assign div_sum   = {1'b0, b_prod_r} + {17'd0, b_prod_r[31:16]} + 33'd1;
  assign delay_sum = {1'b0, c_base_r} + {1'b0, c_quo_r};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind_r <= kind_nxt;
      a_ch_r   <= in_ch;
      a_x_r    <= ~in_level;
      a_span_r <= span_nxt;
      a_base_r <= base_sel;

      b_kind_r <= a_kind_r;
      b_ch_r   <= a_ch_r;
      b_prod_r <= a_x_r * a_span_r;
      b_base_r <= a_base_r;

      c_kind_r <= b_kind_r;
      c_ch_r   <= b_ch_r;
      c_quo_r  <= div_sum[31:16];
      c_base_r <= b_base_r;
    end
  end

  // push finished command, delay saturated to full scale
  assign push           = c_v_r && !q_full;
  assign push_cmd.kind  = c_kind_r;
  assign push_cmd.ch    = c_ch_r;
  assign push_cmd.delay = delay_sum[16] ? FULL_SCALE : delay_sum[15:0];

endmodule
`default_nettype wire

/* rtl/ecpd_fifo.sv */
// Short command queue decoupling the mapping front end from the back end.
// Depends on ecpd_pkg for the command type and depth.
`default_nettype none
module ecpd_fifo (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  ecpd_pkg::cmd_t  push_cmd,
  output logic            full,
  input  wire logic       pop,
  output ecpd_pkg::cmd_t  pop_cmd,
  output logic            not_empty
);
  import ecpd_pkg::*;

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      if (push && !pop)      cnt_r <= cnt_r + (QAW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (QAW+1)'(1);
    end
  end

endmodule
`default_nettype wire

/* rtl/ecpd_back.sv */
// Back end: per-channel delays, tick counter, gate compare and output register.
// Depends on ecpd_pkg.
`default_nettype none
module ecpd_back #(
  parameter int CHANNELS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_not_empty,
  input  ecpd_pkg::cmd_t                     q_cmd,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ecpd_pkg::GATE_W-1:0]        out_gates
);
  import ecpd_pkg::*;

  logic [15:0]       pending_r [CHANNELS];
  logic [15:0]       active_r  [CHANNELS];
  logic [15:0]       tick_r, tick_nxt;
  logic [GATE_W-1:0] gates_r, gates_nxt, hits;
  logic              out_v_r;
  logic [GATE_W-1:0] out_data_r;

  assign pop       = q_not_empty && (!out_v_r || out_ready);
  assign out_valid = out_v_r;
  assign out_gates = out_data_r;

  // saturating tick advance
  assign tick_nxt = (tick_r == FULL_SCALE) ? tick_r : tick_r + 16'd1;

  // per-channel fire compare against the advanced counter
  for (genvar k = 0; k < GATE_W; k++) begin : g_hit
    if (k < CHANNELS) begin : g_on
      assign hits[k] = (active_r[k] != FULL_SCALE) && (tick_nxt >= active_r[k]);
    end else begin : g_off
      assign hits[k] = 1'b0;
    end
  end

  // gate state after this command
  always_comb begin
    unique case (q_cmd.kind)
      CMD_ZERO: gates_nxt = '0;
      CMD_TICK: gates_nxt = gates_r | hits;
      CMD_SET:  gates_nxt = gates_r;
      CMD_NOP:  gates_nxt = gates_r;
    endcase
  end

  // channel delays
  for (genvar k = 0; k < CHANNELS; k++) begin : g_ch
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pending_r[k] <= FULL_SCALE;
        active_r[k]  <= FULL_SCALE;
      end else if (pop) begin
        if (q_cmd.kind == CMD_SET && {2'b00, q_cmd.ch} == 5'(k)) begin
          pending_r[k] <= q_cmd.delay;
        end
        if (q_cmd.kind == CMD_ZERO) begin
          active_r[k] <= pending_r[k];
        end
      end
    end
  end

  // counter and gates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= FULL_SCALE;
      gates_r <= '0;
    end else if (pop) begin
      gates_r <= gates_nxt;
      if (q_cmd.kind == CMD_ZERO)      tick_r <= 16'd0;
      else if (q_cmd.kind == CMD_TICK) tick_r <= tick_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (pop) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= gates_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/eight_channel_phase_dimmer_top.sv */
// Phase-angle AC dimmer for up to CHANNELS triac outputs: one gate word per
// input word, always. A new word is accepted every clock when the output is
// drained; the result passes through the three-stage delay mapping
// (operands, 16x16 multiply, divide by 65535), the four-entry command queue
// and the output register. Each stage handles one word per clock, so
// sustained throughput is one word per cycle while the output is drained.
// Config writes (index 0 mains_60hz, index 1 min_delay) take effect on later
// set-level words only. Depends on ecpd_pkg, ecpd_front, ecpd_fifo,
// ecpd_back.
`default_nettype none
module eight_channel_phase_dimmer_top #(
  parameter int CHANNELS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [2:0] channel, [18:3] level, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [7:0] gates
);
  import ecpd_pkg::*;

  logic push, q_full, pop, q_not_empty;
  cmd_t push_cmd, pop_cmd;

  ecpd_front #(.CHANNELS(CHANNELS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_ch    (in_tdata[2:0]),
    .in_level (in_tdata[18:3]),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  ecpd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .not_empty(q_not_empty)
  );

  ecpd_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_cmd      (pop_cmd),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_gates  (out_tdata)
  );

endmodule
`default_nettype wire
